// ===== design/mhtq_pkg.sv =====
package mhtq_pkg;
  localparam int CAPACITY = 64;
  localparam int TIME_BITS = 32;
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W = SLOT_W + 1;
  localparam int HANDLE_W = 6;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ADJUST = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [2:0] KIND_DONE      = 3'd0;
  localparam logic [2:0] KIND_FIRED     = 3'd1;
  localparam logic [2:0] KIND_CANCELLED = 3'd2;
  localparam logic [2:0] KIND_FULL      = 3'd3;
  localparam logic [2:0] KIND_BAD_SLOT  = 3'd4;

  typedef struct packed {
    logic [2:0]          kind;
    logic [HANDLE_W-1:0] handle;
    logic [5:0]          position;
    logic                last;
  } result_t;
endpackage

// ===== design/mhtq_ram.sv =====
module mhtq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/min_heap_timer_queue.sv =====
// Binary min-heap of up to 64 timers keyed by a 32-bit expiry time.
// Input channel s_axis: one beat is one command (insert, adjust, cancel,
// tick). Output channel m_axis: result beats; tlast marks the final result
// of a command. Insert, adjust and cancel give one result. A tick gives one
// result per popped root (fired or cancelled entry), or a single "done" when
// no timer is due. A pop beat is held until the next root has been checked,
// so that tlast can be set on the final pop.
// Steps: an insert compares its key with one parent per level as it
// rises. An adjust sinks the new key from its slot, one level at a time.
// A tick with nothing due only reads and checks the root. Each popped
// root has its live flag read; the last entry is then moved to the root
// and sunk before the pop beat is sent.
// s_axis_tready is high only while the sequencer is idle; one command is
// in flight at a time. Heap state lives in RAMs with registered reads.
// Reset empties the heap (count to zero); stores are not cleared and
// entries beyond count are never read for results.
// A stalled receiver holds the sequencer in the result state: the result
// register keeps its beat until m_axis_tready, and no heap work advances.
module min_heap_timer_queue
  import mhtq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: op[1:0], handle[7:2], slot[13:8], expire[45:14],
  // now[77:46], zero fill to 80 bits.
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: kind[2:0], out_handle[8:3], position[14:9], zero fill.
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDP    = 4'd1;  // read parent (insert)
  localparam logic [3:0] S_CMPP   = 4'd2;
  localparam logic [3:0] S_RDC0   = 4'd3;  // read left child
  localparam logic [3:0] S_RDC1   = 4'd4;  // read right child
  localparam logic [3:0] S_CMPC   = 4'd5;
  localparam logic [3:0] S_PLACE  = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;
  localparam logic [3:0] S_TROOT  = 4'd8;  // tick: read root
  localparam logic [3:0] S_TCHK   = 4'd9;
  localparam logic [3:0] S_TLIVE  = 4'd10;
  localparam logic [3:0] S_TLAST  = 4'd11; // read last entry
  localparam logic [3:0] S_TLOAD  = 4'd12;
  localparam logic [3:0] S_TWAIT  = 4'd13;
  localparam logic [3:0] S_LOAD   = 4'd14; // take the entry that will sink

  logic [3:0]           state;
  logic [1:0]           op;
  logic [TIME_BITS-1:0] key, now;
  logic [HANDLE_W-1:0]  own;
  logic [SLOT_W-1:0]    hole;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     pops;
  logic [TIME_BITS-1:0] ckey;
  logic [HANDLE_W-1:0]  cown;
  logic [SLOT_W-1:0]    cidx;
  logic                 popped_any;
  result_t              res;

  // Shared key/owner RAM port signals, followed by the live-flag RAM port.
  logic                 k_we;
  logic [SLOT_W-1:0]    k_waddr, k_raddr;
  logic [TIME_BITS-1:0] k_wdata, k_rdata;
  logic [HANDLE_W-1:0]  o_wdata, o_rdata;
  logic [HANDLE_W-1:0]  l_raddr;
  logic                 l_rdata;
  logic                 l_we;
  logic [HANDLE_W-1:0]  l_waddr;
  logic                 l_wdata;

  mhtq_ram #(.DEPTH(CAPACITY), .WIDTH(TIME_BITS)) u_key (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata));
  mhtq_ram #(.DEPTH(CAPACITY), .WIDTH(HANDLE_W)) u_own (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(o_wdata), .raddr(k_raddr), .rdata(o_rdata));
  // The per-handle slot map never affects a result, so it is not stored.
  mhtq_ram #(.DEPTH(64), .WIDTH(1)) u_live (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr),
    .rdata(l_rdata));

  logic [SLOT_W:0]   lchild;
  logic [CNT_W-1:0]  lim;
  assign lchild = {hole, 1'b1};
  assign lim = count - CNT_W'(1);

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {1'b0, res.position, res.handle, res.kind};
  assign m_axis_tlast  = res.last;

  always_comb begin
    k_raddr = hole;
    case (state)
      S_IDLE:  k_raddr = s_axis_tdata[13:8];
      S_RDP:   k_raddr = SLOT_W'((hole - SLOT_W'(1)) >> 1);
      S_RDC0:  k_raddr = lchild[SLOT_W-1:0];
      S_RDC1:  k_raddr = lchild[SLOT_W-1:0] + SLOT_W'(1);
      S_TROOT: k_raddr = '0;
      S_TLAST: k_raddr = count[SLOT_W-1:0];
      default: k_raddr = hole;
    endcase
  end

  always_ff @(posedge clk) begin
    k_we <= 1'b0;
    l_we <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          op         <= s_axis_tdata[1:0];
          key        <= s_axis_tdata[45:14];
          now        <= s_axis_tdata[77:46];
          own        <= s_axis_tdata[7:2];
          pops       <= '0;
          popped_any <= 1'b0;
          case (s_axis_tdata[1:0])
            OP_INSERT: begin
              if (count == CNT_W'(CAPACITY)) begin
                res   <= '{KIND_FULL, s_axis_tdata[7:2], 6'd0, 1'b1};
                state <= S_OUT;
              end else begin
                hole  <= count[SLOT_W-1:0];
                count <= count + CNT_W'(1);
                state <= (count == '0) ? S_PLACE : S_RDP;
              end
            end
            OP_ADJUST: begin
              if (CNT_W'(s_axis_tdata[13:8]) >= count) begin
                res   <= '{KIND_BAD_SLOT, 6'd0, 6'd0, 1'b1};
                state <= S_OUT;
              end else begin
                // The owner of the adjusted slot is read on this edge.
                hole  <= s_axis_tdata[13:8];
                state <= S_LOAD;
              end
            end
            OP_CANCEL: begin
              l_we    <= 1'b1;
              l_waddr <= s_axis_tdata[7:2];
              l_wdata <= 1'b0;
              res     <= '{KIND_DONE, s_axis_tdata[7:2], 6'd0, 1'b1};
              state   <= S_OUT;
            end
            default: state <= S_TROOT;
          endcase
        end
        S_RDP: state <= S_CMPP;
        S_CMPP: begin
          if (k_rdata <= key) begin
            state <= S_PLACE;
          end else begin
            k_we    <= 1'b1;
            k_waddr <= hole;
            k_wdata <= k_rdata;
            o_wdata <= o_rdata;
            hole    <= SLOT_W'((hole - SLOT_W'(1)) >> 1);
            state   <= (((hole - SLOT_W'(1)) >> 1) == '0) ? S_PLACE : S_RDP;
          end
        end
        S_LOAD: begin
          own <= o_rdata;
          if (op == OP_TICK) begin
            key <= k_rdata;
          end
          state <= S_RDC0;
        end
        S_RDC0: begin
          if (CNT_W'(lchild) > lim || count == '0) begin
            state <= S_PLACE;
          end else begin
            state <= S_RDC1;
          end
        end
        S_RDC1: begin
          ckey  <= k_rdata;
          cown  <= o_rdata;
          cidx  <= lchild[SLOT_W-1:0];
          state <= S_CMPC;
        end
        S_CMPC: begin
          logic [TIME_BITS-1:0] bk;
          logic [HANDLE_W-1:0]  bo;
          logic [SLOT_W-1:0]    bi;
          bk = ckey; bo = cown; bi = cidx;
          if (CNT_W'(lchild) < lim && k_rdata < ckey) begin
            bk = k_rdata; bo = o_rdata; bi = cidx + SLOT_W'(1);
          end
          if (bk < key) begin
            k_we    <= 1'b1;
            k_waddr <= hole;
            k_wdata <= bk;
            o_wdata <= bo;
            hole    <= bi;
            state   <= S_RDC0;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          k_we    <= 1'b1;
          k_waddr <= hole;
          k_wdata <= key;
          o_wdata <= own;
          if (op == OP_INSERT) begin
            l_we    <= 1'b1;
            l_waddr <= own;
            l_wdata <= 1'b1;
            res     <= '{KIND_DONE, own, 6'(hole), 1'b1};
            state   <= S_OUT;
          end else if (op == OP_ADJUST) begin
            res   <= '{KIND_DONE, own, 6'(hole), 1'b1};
            state <= S_OUT;
          end else begin
            state <= S_TWAIT;
          end
        end
        S_TWAIT: state <= S_TROOT;
        S_OUT: if (m_axis_tready) begin
          if (op == OP_TICK && !res.last) begin
            // The held pop beat is gone; the due root is popped next.
            popped_any <= 1'b0;
            state      <= S_TROOT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_TROOT: state <= S_TCHK;
        S_TCHK: begin
          if (count != '0 && pops != CNT_W'(CAPACITY) && k_rdata <= now) begin
            if (popped_any) begin
              // Another pop follows, so the held beat is not the last one.
              state <= S_OUT;
            end else begin
              l_raddr <= o_rdata;
              cown    <= o_rdata;
              state   <= S_TLIVE;
            end
          end else if (!popped_any) begin
            res   <= '{KIND_DONE, 6'd0, 6'd0, 1'b1};
            state <= S_OUT;
          end else begin
            // The held pop beat is the final result of this tick.
            res.last <= 1'b1;
            state    <= S_OUT;
          end
        end
        S_TLIVE: state <= S_TLOAD;
        S_TLOAD: begin
          popped_any <= 1'b1;
          pops       <= pops + CNT_W'(1);
          count      <= count - CNT_W'(1);
          res        <= '{(l_rdata ? KIND_FIRED : KIND_CANCELLED), cown, 6'd0, 1'b0};
          state      <= (count == CNT_W'(1)) ? S_TROOT : S_TLAST;
        end
        S_TLAST: begin
          state <= S_LOAD;
          hole  <= '0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)));
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid));
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY));
  a_state_legal: assert property (@(posedge clk) disable iff (rst)
    state <= S_LOAD);
endmodule
